// ===== sv/velocity_command_limiter_unit_macros.svh =====
// Assertion macros for the velocity command limiter.
`ifndef VELOCITY_COMMAND_LIMITER_UNIT_MACROS_SVH
`define VELOCITY_COMMAND_LIMITER_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define VCL_ASSERT_NOW(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("velocity limiter check failed");

// Condition holds in the cycle after the trigger.
`define VCL_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("velocity limiter check failed");

`endif

// ===== sv/vcl_pkg.sv =====
// Package with types and constants of the velocity command limiter.
`timescale 1ns / 1ps
package vcl_pkg;

	localparam int IN_TDATA_W  = 136;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_TUSER_W = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [19:0] US_PER_S = 20'd1000000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HSPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VSPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HACCEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VACCEL = 3'd5;

	typedef enum logic [1:0] {
		FLT_NONE = 2'd0,
		FLT_CMD  = 2'd1,
		FLT_DT   = 2'd2,
		FLT_ALT  = 2'd3
	} fault_t;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_CLAMP  = 14'b00000000000010,
		S_SQX    = 14'b00000000000100,
		S_SQY    = 14'b00000000001000,
		S_SQL    = 14'b00000000010000,
		S_SQRT   = 14'b00000000100000,
		S_MULX   = 14'b00000001000000,
		S_DIVX   = 14'b00000010000000,
		S_MULY   = 14'b00000100000000,
		S_DIVY   = 14'b00001000000000,
		S_STEP   = 14'b00010000000000,
		S_STPDIV = 14'b00100000000000,
		S_VERT   = 14'b01000000000000,
		S_WB     = 14'b10000000000000
	} state_t;

endpackage

// ===== sv/velocity_command_limiter_unit.sv =====
// Velocity command limiter: one shared multiplier, bit-serial square root and divider.
// A faulted word goes straight to the output. Otherwise each horizontal pass (speed,
// then rate) runs a bit-serial root and two divisions when its vector is scaled,
// and a division for each acceleration step. One word is processed at a time; the
// next word is taken only once the result is loaded into the output register.
// Reset (arst_n low) clears config, state, history and the output valid at once.
`timescale 1ns / 1ps
`include "velocity_command_limiter_unit_macros.svh"
module velocity_command_limiter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// req_x, req_y, req_z, req_yaw, altitude_now, ceiling_altitude, step_time, pad
	input  logic [vcl_pkg::IN_TDATA_W-1:0]  s_tdata,
	// clear_history, bad_value
	input  logic [vcl_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_x, out_y, out_z, out_yaw
	output logic [vcl_pkg::OUT_TDATA_W-1:0] m_tdata,
	// fault_code
	output logic [vcl_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import vcl_pkg::*;

	// Configuration registers.
	logic        [14:0] max_hs_q, max_vs_q, max_ys_q;
	logic signed [23:0] floor_q;
	logic        [15:0] acc_h_q, acc_v_q;

	// Control state.
	state_t             state_q;
	logic               ph_q;
	logic               mvalid_q;
	logic signed [15:0] last_x_q, last_y_q, last_z_q;

	// Datapath registers.
	logic signed [15:0] tx_q, ty_q, tz_q, tyaw_q;
	logic signed [23:0] alt_q, ceil_q;
	logic        [19:0] dt_q;
	fault_t             fault_q;
	logic               gate_q;
	logic signed [16:0] vx_q, vy_q;
	logic        [16:0] lim_q;
	logic        [33:0] acc_q;
	logic        [33:0] sq_q;
	logic        [16:0] root_q;
	logic        [19:0] srem_q;
	logic        [16:0] m_q;
	logic        [36:0] dvd_q, quo_q;
	logic        [19:0] dvs_q, rem_q;
	logic        [5:0]  cnt_q;
	logic        [63:0] out_data_q;
	fault_t             out_fault_q;

	// Input fields.
	logic               in_clr, in_bad;
	logic signed [23:0] in_ceil;
	logic        [19:0] in_dt;
	fault_t             in_fault;
	logic               s_fire, out_load;

	assign in_clr  = s_tuser[0];
	assign in_bad  = s_tuser[1];
	assign in_ceil = s_tdata[111:88];
	assign in_dt   = s_tdata[131:112];
	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_load = (state_q == S_WB) && (!mvalid_q || m_tready);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_fault_q;

	// Fault classification of an incoming word.
	always_comb begin
		if (in_bad || (in_ceil <= floor_q)) begin
			in_fault = FLT_CMD;
		end else if (in_dt == 20'd0) begin
			in_fault = FLT_DT;
		end else begin
			in_fault = FLT_NONE;
		end
	end

	// Magnitudes of the working vector.
	logic [16:0] abs_vx, abs_vy;
	assign abs_vx = vx_q[16] ? 17'(-vx_q) : 17'(vx_q);
	assign abs_vy = vy_q[16] ? 17'(-vy_q) : 17'(vy_q);

	// Shared multiplier; its product is combinational.
	logic [16:0] mul_a;
	logic [19:0] mul_b;
	logic [36:0] mul_p;
	always_comb begin
		case (state_q)
			S_SQX: begin
				mul_a = abs_vx;
				mul_b = {3'b0, abs_vx};
			end
			S_SQY: begin
				mul_a = abs_vy;
				mul_b = {3'b0, abs_vy};
			end
			S_SQL: begin
				mul_a = lim_q;
				mul_b = {3'b0, lim_q};
			end
			S_MULX: begin
				mul_a = abs_vx;
				mul_b = {3'b0, lim_q};
			end
			S_MULY: begin
				mul_a = abs_vy;
				mul_b = {3'b0, lim_q};
			end
			S_STEP: begin
				mul_a = {1'b0, (ph_q ? acc_v_q : acc_h_q)};
				mul_b = dt_q;
			end
			default: begin
				mul_a = 17'd0;
				mul_b = 20'd0;
			end
		endcase
	end
	assign mul_p = 37'(mul_a) * 37'(mul_b);

	// One root bit per cycle, two radicand bits consumed.
	logic [21:0] sr_try, sr_trial;
	logic        sq_ge;
	logic [19:0] srem_n;
	logic [16:0] root_n;
	assign sr_try   = {srem_q, sq_q[33:32]};
	assign sr_trial = {3'b0, root_q, 2'b01};
	assign sq_ge    = sr_try >= sr_trial;
	assign srem_n   = sq_ge ? 20'(sr_try - sr_trial) : 20'(sr_try);
	assign root_n   = {root_q[15:0], sq_ge};

	// One quotient bit per cycle, restoring division.
	logic [20:0] dv_try;
	logic        dv_ge;
	logic [19:0] rem_n;
	logic [36:0] quo_n;
	assign dv_try = {rem_q, dvd_q[36]};
	assign dv_ge  = dv_try >= {1'b0, dvs_q};
	assign rem_n  = dv_ge ? 20'(dv_try - {1'b0, dvs_q}) : 20'(dv_try);
	assign quo_n  = {quo_q[35:0], dv_ge};

	// Signed scaled component added to its base.
	logic signed [18:0] q_mag, q_sc, base_ext, comp_new;
	logic               comp_neg;
	logic signed [15:0] comp_base;
	always_comb begin
		comp_neg  = (state_q == S_DIVX) ? vx_q[16] : vy_q[16];
		comp_base = (state_q == S_DIVX) ? last_x_q : last_y_q;
		q_mag     = $signed({1'b0, quo_n[17:0]});
		q_sc      = comp_neg ? -q_mag : q_mag;
		base_ext  = ph_q ? 19'(comp_base) : 19'sd0;
		comp_new  = q_sc + base_ext;
	end

	// Speed clamps and the altitude gate.
	logic signed [16:0] zs, ys, mvs, mys, zc, yc;
	logic               gated;
	always_comb begin
		zs  = 17'(tz_q);
		ys  = 17'(tyaw_q);
		mvs = $signed({2'b0, max_vs_q});
		mys = $signed({2'b0, max_ys_q});
		if (zs > mvs) begin
			zc = mvs;
		end else if (zs < -mvs) begin
			zc = -mvs;
		end else begin
			zc = zs;
		end
		if (ys > mys) begin
			yc = mys;
		end else if (ys < -mys) begin
			yc = -mys;
		end else begin
			yc = ys;
		end
		gated = ((alt_q >= ceil_q) && (zc > 17'sd0)) ||
			((alt_q <= floor_q) && (zc < 17'sd0));
	end

	// Vertical rate limit.
	logic signed [17:0] dz, lim_s, dz_c, z_sum;
	logic signed [15:0] z_new;
	always_comb begin
		dz    = 18'(tz_q) - 18'(last_z_q);
		lim_s = $signed({1'b0, lim_q});
		if (dz > lim_s) begin
			dz_c = lim_s;
		end else if (dz < -lim_s) begin
			dz_c = -lim_s;
		end else begin
			dz_c = dz;
		end
		z_sum = 18'(last_z_q) + dz_c;
		z_new = gate_q ? 16'sd0 : z_sum[15:0];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hs_q <= '0;
			max_vs_q <= '0;
			max_ys_q <= '0;
			floor_q  <= '0;
			acc_h_q  <= '0;
			acc_v_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_HSPEED: max_hs_q <= cfg_data[14:0];
				REG_MAX_VSPEED: max_vs_q <= cfg_data[14:0];
				REG_MAX_YAW:    max_ys_q <= cfg_data[14:0];
				REG_FLOOR:      floor_q  <= $signed(cfg_data[23:0]);
				REG_MAX_HACCEL: acc_h_q  <= cfg_data[15:0];
				REG_MAX_VACCEL: acc_v_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer, history and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= 1'b0;
			mvalid_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			last_z_q <= '0;
		end else begin
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						ph_q <= 1'b0;
						if (in_clr || (in_fault != FLT_NONE)) begin
							last_x_q <= '0;
							last_y_q <= '0;
							last_z_q <= '0;
						end
						state_q <= (in_fault != FLT_NONE) ? S_WB : S_CLAMP;
					end
				end
				S_CLAMP: state_q <= S_SQX;
				S_SQX:   state_q <= S_SQY;
				S_SQY:   state_q <= S_SQL;
				S_SQL:   state_q <= ({3'b0, acc_q} > mul_p) ? S_SQRT : S_STEP;
				S_SQRT: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_DIVX;
				S_DIVX: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_MULY;
					end
				end
				S_MULY: state_q <= S_DIVY;
				S_DIVY: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: state_q <= S_STPDIV;
				S_STPDIV: begin
					if (cnt_q == 6'd0) begin
						ph_q    <= 1'b1;
						state_q <= ph_q ? S_VERT : S_SQX;
					end
				end
				S_VERT: begin
					last_x_q <= tx_q;
					last_y_q <= ty_q;
					last_z_q <= z_new;
					state_q  <= S_WB;
				end
				S_WB: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					fault_q <= in_fault;
					alt_q   <= s_tdata[87:64];
					ceil_q  <= in_ceil;
					dt_q    <= in_dt;
					if (in_fault != FLT_NONE) begin
						tx_q   <= '0;
						ty_q   <= '0;
						tz_q   <= '0;
						tyaw_q <= '0;
					end else begin
						tx_q   <= s_tdata[15:0];
						ty_q   <= s_tdata[31:16];
						tz_q   <= s_tdata[47:32];
						tyaw_q <= s_tdata[63:48];
					end
				end
			end
			S_CLAMP: begin
				tz_q   <= zc[15:0];
				tyaw_q <= yc[15:0];
				gate_q <= gated;
				vx_q   <= 17'(tx_q);
				vy_q   <= 17'(ty_q);
				lim_q  <= {2'b0, max_hs_q};
			end
			S_SQX: acc_q <= mul_p[33:0];
			S_SQY: acc_q <= acc_q + mul_p[33:0];
			S_SQL: begin
				sq_q   <= acc_q;
				root_q <= '0;
				srem_q <= '0;
				cnt_q  <= 6'd16;
			end
			S_SQRT: begin
				sq_q   <= {sq_q[31:0], 2'b00};
				root_q <= root_n;
				srem_q <= srem_n;
				cnt_q  <= cnt_q - 6'd1;
				// Round the root up when a remainder is left.
				m_q    <= root_n + 17'(srem_n != 20'd0);
			end
			S_MULX, S_MULY: begin
				dvd_q <= mul_p;
				dvs_q <= {3'b0, m_q};
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'd36;
			end
			S_STEP: begin
				dvd_q <= mul_p;
				dvs_q <= US_PER_S;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'd36;
			end
			S_DIVX, S_DIVY, S_STPDIV: begin
				dvd_q <= {dvd_q[35:0], 1'b0};
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					case (state_q)
						S_DIVX: tx_q <= comp_new[15:0];
						S_DIVY: ty_q <= comp_new[15:0];
						default: begin
							lim_q <= quo_n[16:0];
							// Difference from the previous command for the rate pass.
							vx_q  <= 17'(tx_q) - 17'(last_x_q);
							vy_q  <= 17'(ty_q) - 17'(last_y_q);
						end
					endcase
				end
			end
			S_VERT: begin
				tz_q <= z_new;
				if (gate_q) begin
					fault_q <= FLT_ALT;
				end
			end
			S_WB: begin
				if (out_load) begin
					out_data_q  <= {tyaw_q, tz_q, ty_q, tx_q};
					out_fault_q <= fault_q;
				end
			end
			default: ;
		endcase
	end

	// History and fault terms used by the checks.
	logic hist_zero, clr_fault;
	assign hist_zero = (last_x_q == 16'sd0) && (last_y_q == 16'sd0) && (last_z_q == 16'sd0);
	assign clr_fault = (fault_q == FLT_CMD) || (fault_q == FLT_DT);

	// Checks.
	`VCL_ASSERT_NEXT(a_bad_faults, s_fire && in_bad, fault_q == FLT_CMD)
	`VCL_ASSERT_NOW(a_gate_zero, m_tvalid && (m_tuser == FLT_ALT), m_tdata[47:32] == 16'd0)
	`VCL_ASSERT_NOW(a_fault_hist, (state_q == S_WB) && clr_fault, hist_zero)

endmodule

// ===== dv/tb_velocity_command_limiter_unit.sv =====
// Self-checking testbench for the velocity command limiter unit.
`timescale 1ns / 1ps
module tb_velocity_command_limiter_unit;
	import vcl_pkg::*;

	typedef struct packed {
		logic                clr;
		logic                bad;
		logic signed [15:0]  vx;
		logic signed [15:0]  vy;
		logic signed [15:0]  vz;
		logic signed [15:0]  yaw;
		logic signed [23:0]  alt;
		logic signed [23:0]  ceil_alt;
		logic [19:0]         dt;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic signed [15:0] yaw;
		fault_t             flt;
	} limited_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [IN_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;

	// Predictor copies of the registers and the velocity history.
	longint lim_hspeed, lim_vspeed, lim_yaw, lim_haccel, lim_vaccel, floor_mm;
	longint hist_x, hist_y, hist_z;

	limited_t expected_cmds[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int hold_cycles = 0;
	bit rx_stall_enable = 1'b1;

	always #10 clk = ~clk;

	velocity_command_limiter_unit u_top (.*);

	// Rounded-up integer square root.
	function automatic longint root_up(longint v);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--)
			if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v)
				r += 64'sd1 << b;
		if (r * r < v)
			r++;
		return r;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Work out the limited command and advance the history.
	function automatic limited_t limit_command(cmd_t c);
		limited_t r;
		longint x, y, z, w, m, stp, dx, dy, mag;
		bit gated;
		r = '0;
		if (c.clr) begin
			hist_x = 0; hist_y = 0; hist_z = 0;
		end
		if (c.bad || longint'(c.ceil_alt) <= floor_mm || c.dt == 0) begin
			hist_x = 0; hist_y = 0; hist_z = 0;
			r.flt = (c.bad || longint'(c.ceil_alt) <= floor_mm) ? FLT_CMD : FLT_DT;
			return r;
		end
		x = c.vx; y = c.vy; z = c.vz; w = c.yaw;
		mag = x * x + y * y;
		if (mag > lim_hspeed * lim_hspeed) begin
			m = root_up(mag);
			x = x * lim_hspeed / m;
			y = y * lim_hspeed / m;
		end
		z = clamp_mag(z, lim_vspeed);
		w = clamp_mag(w, lim_yaw);
		gated = (longint'(c.alt) >= longint'(c.ceil_alt) && z > 0) ||
			(longint'(c.alt) <= floor_mm && z < 0);
		stp = lim_haccel * longint'(c.dt) / 1000000;
		dx = x - hist_x;
		dy = y - hist_y;
		mag = dx * dx + dy * dy;
		if (mag > stp * stp) begin
			m = root_up(mag);
			x = hist_x + dx * stp / m;
			y = hist_y + dy * stp / m;
		end
		stp = lim_vaccel * longint'(c.dt) / 1000000;
		z = hist_z + clamp_mag(z - hist_z, stp);
		r.flt = FLT_NONE;
		if (gated) begin
			z = 0;
			r.flt = FLT_ALT;
		end
		hist_x = x; hist_y = y; hist_z = z;
		r.vx = 16'(x); r.vy = 16'(y); r.vz = 16'(z); r.yaw = 16'(w);
		return r;
	endfunction

	// Register write while the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_HSPEED: lim_hspeed = val & 16'h7FFF;
			REG_MAX_VSPEED: lim_vspeed = val & 16'h7FFF;
			REG_MAX_YAW:    lim_yaw = val & 16'h7FFF;
			REG_FLOOR:      floor_mm = longint'($signed(val[23:0]));
			REG_MAX_HACCEL: lim_haccel = val & 16'hFFFF;
			REG_MAX_VACCEL: lim_vaccel = val & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic set_limits(longint hs, longint vs, longint ys, longint fl,
			longint ha, longint va);
		write_reg(REG_MAX_HSPEED, hs);
		write_reg(REG_MAX_VSPEED, vs);
		write_reg(REG_MAX_YAW, ys);
		write_reg(REG_FLOOR, fl);
		write_reg(REG_MAX_HACCEL, ha);
		write_reg(REG_MAX_VACCEL, va);
	endtask

	// Send one command word after a random gap (none when no_gap is set); the valid
	// stays up after the accepting edge so that a following word can go out back to back.
	task automatic send_cmd(cmd_t c, bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : int'($urandom_range(0, 16));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, c.dt, c.ceil_alt, c.alt, c.yaw, c.vz, c.vy, c.vx};
		s_tuser <= {c.bad, c.clr};
		expected_cmds.push_back(limit_command(c));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.clr = ($urandom_range(0, 15) == 0);
		c.bad = ($urandom_range(0, 31) == 0);
		c.vx = 16'($urandom); c.vy = 16'($urandom);
		c.vz = 16'($urandom); c.yaw = 16'($urandom);
		if ($urandom_range(0, 1)) begin
			c.vx = $signed(c.vx) >>> $urandom_range(0, 12);
			c.vy = $signed(c.vy) >>> $urandom_range(0, 12);
			c.vz = $signed(c.vz) >>> $urandom_range(0, 12);
		end
		c.alt = 24'($urandom);
		c.ceil_alt = 24'($urandom);
		if ($urandom_range(0, 7) != 0) begin
			// Mostly a valid band above the floor with the altitude nearby.
			c.ceil_alt = 24'(floor_mm + longint'($urandom_range(1, 200000)));
			c.alt = 24'(floor_mm + longint'($urandom_range(0, 200000)) - 2000);
			if ($urandom_range(0, 5) == 0)
				c.alt = 24'(longint'(c.ceil_alt) + longint'($urandom_range(0, 3)));
		end
		c.dt = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 50000));
		if ($urandom_range(0, 40) == 0)
			c.dt = 20'd0;
		return c;
	endfunction

	// Output checker.
	always @(posedge clk) begin
		limited_t want, got;
		if (m_tvalid && m_tready) begin
			got.vx = m_tdata[15:0];
			got.vy = m_tdata[31:16];
			got.vz = m_tdata[47:32];
			got.yaw = m_tdata[63:48];
			got.flt = fault_t'(m_tuser);
			if (expected_cmds.size() == 0) begin
				errors++;
				$display("%t: unexpected word %h fault %0d", $time, m_tdata, m_tuser);
			end else begin
				want = expected_cmds.pop_front();
				words_checked++;
				if (want.vx != got.vx)
					$display("%t: out_x exp %0d got %0d", $time, want.vx, got.vx);
				if (want.vy != got.vy)
					$display("%t: out_y exp %0d got %0d", $time, want.vy, got.vy);
				if (want.vz != got.vz)
					$display("%t: out_z exp %0d got %0d", $time, want.vz, got.vz);
				if (want.yaw != got.yaw)
					$display("%t: out_yaw exp %0d got %0d", $time, want.yaw, got.yaw);
				if (want.flt != got.flt)
					$display("%t: fault exp %0d got %0d", $time, want.flt, got.flt);
				if (want != got)
					errors++;
			end
		end
	end

	// Receiver readiness: random stalls, or a long hold when requested.
	initial begin
		int w;
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			w = rx_stall_enable ? int'($urandom_range(0, 16)) : 0;
			if ($urandom_range(0, 3) == 0)
				w = 0;
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic test_directed();
		cmd_t c;
		set_limits(1000, 500, 800, -1000, 2000, 3000);
		c = '0;
		c.ceil_alt = 24'sd50000; c.alt = 24'sd0; c.dt = 20'd20000;
		c.vx = 16'sh7FFF; c.vy = 16'sh8000; c.vz = 16'sh7FFF; c.yaw = 16'sh8000;
		send_cmd(c);
		c.vx = 16'sh8000; c.vy = 16'sh7FFF; c.vz = 16'sh8000; c.yaw = 16'sh7FFF;
		send_cmd(c);
		c.vx = 16'sd300; c.vy = -16'sd400; c.vz = 16'sd100; c.yaw = 16'sd5;
		send_cmd(c);
		// Invalid command by flag, then by an empty altitude band.
		c.bad = 1'b1; send_cmd(c); c.bad = 1'b0;
		c.ceil_alt = -24'sd1000; send_cmd(c);
		c.ceil_alt = 24'sd50000;
		// Invalid time step, and both faults together.
		c.dt = 20'd0; send_cmd(c);
		c.bad = 1'b1; send_cmd(c); c.bad = 1'b0;
		c.dt = 20'hFFFFF; send_cmd(c);
		// Altitude gate at the ceiling and at the floor.
		c.alt = 24'sd50000; c.vz = 16'sd400; send_cmd(c);
		c.alt = -24'sd1000; c.vz = -16'sd400; send_cmd(c);
		c.alt = 24'sh800000; send_cmd(c);
		c.alt = 24'sd0;
		// A tiny time step holds the previous velocity.
		c.dt = 20'd1; c.vx = -16'sd900; send_cmd(c);
		c.clr = 1'b1; c.dt = 20'hFFFFF; send_cmd(c); c.clr = 1'b0;
		c.ceil_alt = 24'sh7FFFFF; send_cmd(c);
		drain();
		// Zero limits everywhere, then the largest ones.
		set_limits(0, 0, 0, 24'h800000, 0, 0);
		c.alt = 24'sd100; send_cmd(c);
		c.vx = 16'sd0; c.vy = 16'sd0; c.dt = 20'd7; send_cmd(c);
		drain();
		set_limits(32767, 32767, 32767, 24'h7FFFFE, 65535, 65535);
		c.ceil_alt = 24'sh7FFFFF; c.alt = 24'sh7FFFFF; c.vx = 16'sh8000;
		c.vy = 16'sh8000; c.vz = 16'sh7FFF; send_cmd(c);
		c.vz = 16'sh8000; send_cmd(c);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 250 == 0) begin
				drain();
				set_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(0, 32767), $signed(24'($urandom)) >>> $urandom_range(0, 12),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			end
			// Every eighth stretch runs back to back.
			send_cmd(rand_cmd(), (i / 40) % 8 == 0);
		end
		drain();
	endtask

	task automatic test_backpressure();
		cmd_t c;
		hold_cycles = 2000;
		for (int i = 0; i < 12; i++) begin
			c = rand_cmd();
			send_cmd(c, 1'b1);
		end
		drain();
	endtask

	initial begin
		lim_hspeed = 0; lim_vspeed = 0; lim_yaw = 0;
		lim_haccel = 0; lim_vaccel = 0; floor_mm = 0;
		hist_x = 0; hist_y = 0; hist_z = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(2000);
		$display("Sent %0d command words, checked %0d limited commands,", words_sent,
			words_checked);
		$display("covering faults, altitude gating, speed and slew limits.");
		if (errors == 0)
			$display("tb_velocity_command_limiter_unit: done, clean");
		else
			$display("tb_velocity_command_limiter_unit: done, errors");
		$finish;
	end

	// Watchdog.
	initial begin
		#100ms;
		$display("Timeout with %0d words outstanding.", expected_cmds.size());
		$display("tb_velocity_command_limiter_unit: done, errors");
		$finish;
	end

endmodule
